// File: hw/rtl/dual_button_debounce_long_press_macros.svh
// Assertion shorthands for the debounce block checkers.
// Each samples on clk and is disabled while arst_n is low.
`ifndef DUAL_BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define DUAL_BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Same-cycle implication.
`define DBDLP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dbdlp assertion failed (same cycle)");

// Next-cycle implication.
`define DBDLP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dbdlp assertion failed (next cycle)");

`endif

// File: hw/rtl/dbdlp_pkg.sv
`default_nettype none
package dbdlp_pkg;

	localparam int NOW_BITS = 32;
	localparam int CFG_BITS = 16;
	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 3;

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 16'd30;
	localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

	// Register word index (paddr[2])
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} ev_t;

	typedef struct packed {
		ev_t  ev;
		logic follow;
	} lane_res_t;

	typedef struct packed {
		ev_t  left_ev;
		ev_t  right_ev;
		logic follow;
	} out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/dbdlp_lane.sv
`default_nettype none
module dbdlp_lane #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [TIME_BITS-1:0]          now,
	input  wire logic                          pin_lvl,
	input  wire logic [dbdlp_pkg::CFG_BITS-1:0] deb_time,
	input  wire logic [dbdlp_pkg::CFG_BITS-1:0] long_time,
	output dbdlp_pkg::lane_res_t               res
);
	import dbdlp_pkg::*;

	logic                 cand_q;
	logic                 stable_q;
	logic                 long_q;
	logic [TIME_BITS-1:0] cct_q;
	logic [TIME_BITS-1:0] press_q;

	logic                 pressed;
	logic                 chg;
	logic [TIME_BITS-1:0] el_cand;
	logic [TIME_BITS-1:0] el_press;
	logic                 deb_hit;
	logic                 deb_press;
	logic                 short_hit;
	logic                 long_hit;
	logic                 stable_n;
	logic                 long_mid;
	logic                 long_n;

	always_comb begin
		pressed   = ~pin_lvl;
		chg       = pressed != cand_q;
		el_cand   = now - cct_q;
		deb_hit   = !chg && (pressed != stable_q) && (el_cand >= TIME_BITS'(deb_time));
		deb_press = deb_hit && pressed;
		short_hit = deb_hit && !pressed && !long_q;
		stable_n  = deb_hit ? pressed : stable_q;
		long_mid  = deb_press ? 1'b0 : long_q;
		// A fresh stable press starts its hold timer now.
		el_press  = deb_press ? '0 : (now - press_q);
		long_hit  = !chg && !short_hit && stable_n && !long_mid &&
		            (el_press >= TIME_BITS'(long_time));
		long_n    = long_mid | long_hit;

		if (short_hit) begin
			res.ev = EV_SHORT;
		end else if (long_hit) begin
			res.ev = EV_LONG;
		end else begin
			res.ev = EV_NONE;
		end
		res.follow = (pressed != stable_n) || (stable_n && !long_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q   <= 1'b0;
			stable_q <= 1'b0;
			long_q   <= 1'b0;
			cct_q    <= '0;
			press_q  <= '0;
		end else if (accept) begin
			cand_q   <= pressed;
			stable_q <= stable_n;
			long_q   <= long_n;
			if (chg) begin
				cct_q <= now;
			end
			if (deb_press) begin
				press_q <= now;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/dbdlp_out.sv
`default_nettype none
module dbdlp_out (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire dbdlp_pkg::lane_res_t left_res,
	input  wire dbdlp_pkg::lane_res_t right_res,
	input  wire logic                 out_stall,
	output logic                      in_stall,
	output logic                      out_valid,
	output dbdlp_pkg::out_item_t      out_item
);
	import dbdlp_pkg::*;

	out_item_t merged;
	out_item_t out_q;
	out_item_t skid_q;
	logic      out_vld_q;
	logic      skid_full_q;
	logic      take;

	always_comb begin
		merged.left_ev  = left_res.ev;
		merged.right_ev = right_res.ev;
		merged.follow   = left_res.follow | right_res.follow;
		take            = out_vld_q && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take) begin
				skid_full_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_vld_q && !take) begin
				skid_full_q <= 1'b1;
			end
			out_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_vld_q && !take) begin
				skid_q <= merged;
			end else begin
				out_q <= merged;
			end
		end
	end

	assign in_stall  = skid_full_q;
	assign out_valid = out_vld_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

// File: hw/rtl/dual_button_debounce_long_press.sv
// Each accepted scan item gives one registered result on the output.
// Throughput: one scan item per cycle while in_stall is low; two lanes, one per button, each a few
// compares on wrapped timestamp differences, merged into one result.
// Output register plus skid entry: input stalls only while both hold results.
// Reset (arst_n low, asynchronous): buttons released, timers zero,
// debounce 30 ms, long press 1000 ms, output empty.
`default_nettype none
module dual_button_debounce_long_press #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// scan item channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [dbdlp_pkg::NOW_BITS-1:0]  now_time,
	input  wire logic                            left_raw_high,
	input  wire logic                            right_raw_high,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           left_event,
	output logic [1:0]                           right_event,
	output logic                                 follow_up,
	// register port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [dbdlp_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [dbdlp_pkg::DATA_BITS-1:0] pwdata,
	output logic [dbdlp_pkg::DATA_BITS-1:0]      prdata,
	output logic                                 pready
);
	import dbdlp_pkg::*;

	logic [CFG_BITS-1:0]  deb_q;
	logic [CFG_BITS-1:0]  long_q;
	logic                 accept;
	logic                 reg_idx;
	logic                 wr_en;
	logic [TIME_BITS-1:0] now;
	lane_res_t            left_res;
	lane_res_t            right_res;
	out_item_t            out_item;

	// Registers sit on 4-byte words; decode by word index only.
	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q  <= DEBOUNCE_RESET;
			long_q <= LONG_PRESS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEBOUNCE:   deb_q  <= pwdata[CFG_BITS-1:0];
				REG_LONG_PRESS: long_q <= pwdata[CFG_BITS-1:0];
				default:        deb_q  <= deb_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEBOUNCE:   prdata = DATA_BITS'(deb_q);
			REG_LONG_PRESS: prdata = DATA_BITS'(long_q);
			default:        prdata = '0;
		endcase
	end

	// Take the scan when the skid entry is free.
	assign accept = in_valid && !in_stall;

	// Fold the timestamp into the wrapping time domain.
	assign now = TIME_BITS'(now_time);

	dbdlp_lane #(
		.TIME_BITS(TIME_BITS)
	) u_lane_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.now       (now),
		.pin_lvl   (left_raw_high),
		.deb_time  (deb_q),
		.long_time (long_q),
		.res       (left_res)
	);

	dbdlp_lane #(
		.TIME_BITS(TIME_BITS)
	) u_lane_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.now       (now),
		.pin_lvl   (right_raw_high),
		.deb_time  (deb_q),
		.long_time (long_q),
		.res       (right_res)
	);

	// Merge lane results and hold them for the result channel.
	dbdlp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.left_res  (left_res),
		.right_res (right_res),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	assign left_event  = out_item.left_ev;
	assign right_event = out_item.right_ev;
	assign follow_up   = out_item.follow;

endmodule
`default_nettype wire

// File: hw/rtl/dbdlp_checker.sv
`default_nettype none
`include "dual_button_debounce_long_press_macros.svh"
module dbdlp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] left_event,
	input wire logic [1:0] right_event,
	input wire logic       follow_up
);

	// A waiting result holds its value.
	`DBDLP_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(left_event) && $stable(right_event) && $stable(follow_up))

	// Input closes only after an item arrived while a result was stuck.
	`DBDLP_ASSERT_IMP(a_stall_cause, $rose(in_stall),
		$past(in_valid) && $past(out_valid) && $past(out_stall))

	// A result never appears without an accepted item.
	`DBDLP_ASSERT_IMP(a_no_invent, $rose(out_valid), $past(in_valid) && !$past(in_stall))

	// Input reopens once the stuck result is taken.
	`DBDLP_ASSERT_NXT(a_stall_release, in_stall && !out_stall, !in_stall)

endmodule

bind dual_button_debounce_long_press dbdlp_checker u_dbdlp_checker (.*);
`default_nettype wire

// File: tb/sv/dual_button_debounce_long_press_checker.sv
`timescale 1ns / 1ps
module dual_button_debounce_long_press_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic [dbdlp_pkg::NOW_BITS-1:0]  now_time,
	input  wire logic                            left_raw_high,
	input  wire logic                            right_raw_high,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [1:0]                      left_event,
	input  wire logic [1:0]                      right_event,
	input  wire logic                            follow_up,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic                            pready,
	input  wire logic [dbdlp_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [dbdlp_pkg::DATA_BITS-1:0] pwdata,
	output int                                   outstanding,
	output int                                   mismatches
);
	import dbdlp_pkg::*;

	// per-button tracker state, index 0 left, 1 right
	logic                cand_pressed [2];
	logic                stable_dn [2];
	logic                long_done [2];
	logic [NOW_BITS-1:0] cand_since [2];
	logic [NOW_BITS-1:0] press_since [2];
	logic [CFG_BITS-1:0] deb_cfg;
	logic [CFG_BITS-1:0] hold_cfg;

	out_item_t awaited_events [$];

	// advance one button by one scan and return its event
	task automatic debounce_button(input int b, input logic pin_lvl,
		input logic [NOW_BITS-1:0] now, output ev_t ev);
		logic                pressed;
		logic [NOW_BITS-1:0] gap;
		pressed = !pin_lvl;
		ev = EV_NONE;
		if (pressed != cand_pressed[b]) begin
			cand_pressed[b] = pressed;
			cand_since[b] = now;
		end else begin
			gap = now - cand_since[b];
			if (pressed != stable_dn[b] && gap >= {16'd0, deb_cfg}) begin
				stable_dn[b] = pressed;
				if (pressed) begin
					press_since[b] = now;
					long_done[b] = 1'b0;
				end else if (!long_done[b]) begin
					ev = EV_SHORT;
				end
			end
			gap = now - press_since[b];
			if (ev == EV_NONE && stable_dn[b] && !long_done[b] &&
				gap >= {16'd0, hold_cfg}) begin
				long_done[b] = 1'b1;
				ev = EV_LONG;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		ev_t       ev_l;
		ev_t       ev_r;
		if (!arst_n) begin
			for (int b = 0; b < 2; b++) begin
				cand_pressed[b] = 1'b0;
				stable_dn[b] = 1'b0;
				long_done[b] = 1'b0;
				cand_since[b] = '0;
				press_since[b] = '0;
			end
			deb_cfg = DEBOUNCE_RESET;
			hold_cfg = LONG_PRESS_RESET;
			awaited_events.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (awaited_events.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result left=%0d right=%0d follow=%0d",
						$time, left_event, right_event, follow_up);
				end else begin
					want = awaited_events.pop_front();
					if (left_event !== want.left_ev) begin
						mismatches++;
						$display("%0t: left_event expected %0d actual %0d",
							$time, want.left_ev, left_event);
					end
					if (right_event !== want.right_ev) begin
						mismatches++;
						$display("%0t: right_event expected %0d actual %0d",
							$time, want.right_ev, right_event);
					end
					if (follow_up !== want.follow) begin
						mismatches++;
						$display("%0t: follow_up expected %0d actual %0d",
							$time, want.follow, follow_up);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_DEBOUNCE)
					deb_cfg = pwdata[CFG_BITS-1:0];
				else
					hold_cfg = pwdata[CFG_BITS-1:0];
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				debounce_button(0, left_raw_high, now_time, ev_l);
				debounce_button(1, right_raw_high, now_time, ev_r);
				want.left_ev = ev_l;
				want.right_ev = ev_r;
				want.follow = 1'b0;
				for (int b = 0; b < 2; b++)
					if (cand_pressed[b] != stable_dn[b] ||
						(stable_dn[b] && !long_done[b]))
						want.follow = 1'b1;
				awaited_events.push_back(want);
			end
			outstanding <= awaited_events.size();
		end
	end

endmodule

// File: tb/sv/dual_button_debounce_long_press_tb.sv
`timescale 1ns / 1ps
module dual_button_debounce_long_press_tb;
	import dbdlp_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [NOW_BITS-1:0]  now_time = '0;
	logic                 left_raw_high = 1'b1;
	logic                 right_raw_high = 1'b1;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           left_event;
	logic [1:0]           right_event;
	logic                 follow_up;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	int outstanding;
	int mismatches;

	// stimulus-side view of the scan clock and the current settings
	logic [NOW_BITS-1:0] clock_ms = '0;
	int                  db_ms = 30;
	int                  lp_ms = 1000;
	// suppress all idling on both sides while set
	logic                calm = 1'b0;

	dual_button_debounce_long_press dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_time(now_time),
		.left_raw_high(left_raw_high),
		.right_raw_high(right_raw_high),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_event(left_event),
		.right_event(right_event),
		.follow_up(follow_up),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	dual_button_debounce_long_press_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_time(now_time),
		.left_raw_high(left_raw_high),
		.right_raw_high(right_raw_high),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_event(left_event),
		.right_event(right_event),
		.follow_up(follow_up),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.outstanding(outstanding),
		.mismatches(mismatches)
	);

	always #5 clk = ~clk;

	// hold reset low from time zero, then release it for good
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// stall the result side at random, except during the calm stretch
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 17);
	end

	// Drive one scan item and hold it until accepted. Called right after a
	// rising edge; returns at the edge that accepted the item, with valid
	// still high so a back-to-back item needs only one assignment.
	task automatic scan_item(input logic [NOW_BITS-1:0] t, input logic l, input logic r);
		if (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_time <= t;
		left_raw_high <= l;
		right_raw_high <= r;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Drop valid and wait until every result is back plus the pipeline depth.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// setup cycle, then access cycle; the write lands at the access edge
	task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reconfigure(input int db, input int lp);
		settle();
		write_reg(REG_DEBOUNCE, db[CFG_BITS-1:0]);
		write_reg(REG_LONG_PRESS, lp[CFG_BITS-1:0]);
		db_ms = db;
		lp_ms = lp;
	endtask

	// Random press traffic. Each button flips its intended level after a
	// random hold: a glitch no longer than debounce, a short press, a long
	// press or anything in between. Bounce right after each flip, and mix
	// in some pure noise and the odd jump of the timestamp.
	task automatic press_traffic(input int n_items);
		int                  step_max;
		logic                pressed [2];
		logic [NOW_BITS-1:0] start_ms [2];
		int                  hold_ms [2];
		logic [NOW_BITS-1:0] since;
		logic                raw [2];
		step_max = (db_ms + lp_ms) / 40 + 1;
		for (int b = 0; b < 2; b++) begin
			pressed[b] = 1'b0;
			start_ms[b] = clock_ms;
			hold_ms[b] = $urandom_range(0, lp_ms);
		end
		repeat (n_items) begin
			clock_ms += $urandom_range(0, step_max);
			if ($urandom_range(99) < 2)
				clock_ms = $urandom;
			for (int b = 0; b < 2; b++) begin
				since = clock_ms - start_ms[b];
				if (since >= hold_ms[b]) begin
					pressed[b] = !pressed[b];
					start_ms[b] = clock_ms;
					since = '0;
					case ($urandom_range(3))
						0: hold_ms[b] = $urandom_range(0, db_ms);
						1: hold_ms[b] = $urandom_range(db_ms, db_ms + lp_ms);
						2: hold_ms[b] = $urandom_range(db_ms + lp_ms, db_ms + 2 * lp_ms + 1);
						default: hold_ms[b] = $urandom_range(0, 3 * lp_ms + 1);
					endcase
				end
				raw[b] = !pressed[b];
				// contact bounce during the first half of the debounce window
				if (since < db_ms / 2 + 1 && $urandom_range(2) == 0)
					raw[b] = pressed[b];
			end
			if ($urandom_range(99) < 8) begin
				raw[0] = 1'($urandom_range(1));
				raw[1] = 1'($urandom_range(1));
			end
			scan_item(clock_ms, raw[0], raw[1]);
		end
	endtask

	initial begin
		int guard;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed part at the reset settings (debounce 30, long press 1000).
		scan_item(32'd0, 1'b1, 1'b1);
		// left: press with one bounce, then held into a long event
		scan_item(32'd5, 1'b0, 1'b1);
		scan_item(32'd20, 1'b0, 1'b1);
		scan_item(32'd35, 1'b0, 1'b1);
		scan_item(32'd40, 1'b1, 1'b1);
		scan_item(32'd45, 1'b0, 1'b1);
		scan_item(32'd80, 1'b0, 1'b1);
		scan_item(32'd1035, 1'b0, 1'b1);
		// release after the long event reports nothing
		scan_item(32'd1040, 1'b1, 1'b1);
		scan_item(32'd1080, 1'b1, 1'b1);
		// both buttons short-pressed together
		scan_item(32'd1100, 1'b0, 1'b0);
		scan_item(32'd1140, 1'b0, 1'b0);
		scan_item(32'd1150, 1'b1, 1'b1);
		scan_item(32'd1190, 1'b1, 1'b1);
		// debounce across the timestamp wrap, then a long press
		scan_item(32'hFFFF_FFF0, 1'b0, 1'b1);
		scan_item(32'h0000_0010, 1'b0, 1'b1);
		scan_item(32'h0000_03F8, 1'b0, 1'b1);
		// timestamp extremes, same timestamp twice
		scan_item(32'hFFFF_FFFF, 1'b1, 1'b0);
		scan_item(32'hFFFF_FFFF, 1'b1, 1'b0);
		scan_item(32'hAAAA_5555, 1'b1, 1'b0);
		scan_item(32'h5555_AAAA, 1'b1, 1'b1);
		scan_item(32'd0, 1'b1, 1'b1);
		clock_ms = '0;

		// Random part across several settings, extremes included.
		press_traffic(250);
		reconfigure(1, 2);
		press_traffic(200);
		// zero times: every comparison passes
		reconfigure(0, 0);
		press_traffic(150);
		// long press not above debounce
		reconfigure(5, 3);
		press_traffic(200);
		// one long stretch with no idling on either side
		reconfigure($urandom_range(1, 40), $urandom_range(2, 300));
		calm <= 1'b1;
		press_traffic(250);
		settle();
		calm <= 1'b0;
		reconfigure(65535, 65535);
		press_traffic(200);
		reconfigure(1, 65535);
		press_traffic(150);
		reconfigure(12, 80);
		press_traffic(150);

		// drain the results, bounded
		in_valid <= 1'b0;
		guard = 0;
		while (outstanding != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// end a hung run
	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
